>>> rtl/bmft_pkg.sv
// ============================================================================
// bmft_pkg
// Shared constants and types of the block-mapped flash translation block.
// ============================================================================
package bmft_pkg;

   // Flash geometry. Both counts are powers of two so that a page address is
   // the block number followed by the page offset.
   localparam int PAGES_PER_BLK = 4;
   localparam int NUM_BLOCKS    = 16;
   localparam int DATA_BLOCKS   = NUM_BLOCKS - 1;

   localparam int OFF_W    = $clog2(PAGES_PER_BLK);
   localparam int BLK_W    = $clog2(NUM_BLOCKS);
   localparam int PAGE_W   = BLK_W + OFF_W;
   localparam int SECTOR_W = 6;
   localparam int CMD_W    = 3;

   // Flash command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 3'd0,
      CMD_PROG  = 3'd1,
      CMD_MARK  = 3'd2,
      CMD_COPY  = 3'd3,
      CMD_ERASE = 3'd4
   } cmd_type;

   // Request type codes
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Kind of write, settled once the page row is known
   typedef enum logic [1:0] {
      WR_FRESH = 2'd0,   // first write to an unmapped logical block
      WR_FILL  = 2'd1,   // write to an unused page of a mapped block
      WR_MOVE  = 2'd2    // overwrite: rewrite the block into the free block
   } wr_kind_type;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MAP   = 7'b0000010,
      S_ROW   = 7'b0000100,
      S_MARK  = 7'b0001000,
      S_COPY  = 7'b0010000,
      S_PROG  = 7'b0100000,
      S_ERASE = 7'b1000000
   } state_type;

endpackage

>>> rtl/block_map_flash_translation.sv
// ============================================================================
// block_map_flash_translation
// Block-mapped flash translation: turns sector read and write requests into
// flash page commands.
// ============================================================================
// One request at a time. A request is a read or a write of one logical sector
// (logical block in the upper bits, page offset in the lower bits). The block
// answers with one or more flash commands on the rsp_ channel, the final one
// flagged by rsp_last; a write beyond the last logical block gives no command.
// The logical-to-physical map and the per-block page-use rows sit in two small
// synchronous memories with a registered read. A read looks up the map and
// answers from that lookup; a write does two lookups (map, then page row)
// before its first command, and an overwrite then runs the copy loop, which
// walks the page offsets one per cycle while the output register has room.
// A full output register stalls the sequencer; the next request is taken once
// the last command of the current one has been loaded into it.
// After reset every logical block is unmapped, every page is free and block 0
// is the spare block; per-entry valid flops make this hold at once, with no
// clearing pass.
module block_map_flash_translation
   import bmft_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [SECTOR_W-1:0] req_sector_num,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CMD_W-1:0]    rsp_cmd,
   output logic [PAGE_W-1:0]   rsp_page_addr,
   output logic [PAGE_W-1:0]   rsp_src_page_addr,
   output logic [BLK_W-1:0]    rsp_block_addr,
   output logic                rsp_status,
   output logic                rsp_last
);

   // ------------------------------------------------------------------------
   // State memories
   // ------------------------------------------------------------------------
   // Logical-to-physical map, one entry per data block, plus a mapped flag
   logic [BLK_W-1:0]         map_mem [DATA_BLOCKS];
   logic [DATA_BLOCKS-1:0]   map_vld_ff;
   // Page-use bitmap, one row of page bits per physical block; a row never
   // written reads as all clear
   logic [PAGES_PER_BLK-1:0] row_mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0]    row_vld_ff;
   // Spare block
   logic [BLK_W-1:0]         free_ff;

   // ------------------------------------------------------------------------
   // Request context
   // ------------------------------------------------------------------------
   state_type                state_ff, state_in;
   logic                     is_wr_ff;
   logic [BLK_W-1:0]         lbn_ff;
   logic [OFF_W-1:0]         off_ff;
   logic                     lbn_ok_ff;
   logic                     hit_ff;
   logic [BLK_W-1:0]         map_q_ff;
   logic [BLK_W-1:0]         tgt_ff, tgt_in;
   logic [PAGES_PER_BLK-1:0] row_q_ff;
   logic                     row_qv_ff;
   wr_kind_type              kind_ff, kind_in;
   logic [OFF_W-1:0]         idx_ff, idx_in;

   // Output register
   logic                     rsp_valid_ff;
   cmd_type                  rsp_cmd_ff;
   logic [PAGE_W-1:0]        rsp_page_ff;
   logic [PAGE_W-1:0]        rsp_src_ff;
   logic [BLK_W-1:0]         rsp_blk_ff;
   logic                     rsp_status_ff;
   logic                     rsp_last_ff;

   // ------------------------------------------------------------------------
   // Combinational signals
   // ------------------------------------------------------------------------
   logic                     req_fire;
   logic [BLK_W-1:0]         req_lbn;
   logic [OFF_W-1:0]         req_off;
   logic                     req_lbn_ok;
   logic                     slot_free;
   logic [PAGES_PER_BLK-1:0] row_cur;
   logic [PAGES_PER_BLK-1:0] off_bit;
   logic [BLK_W-1:0]         prog_blk;

   logic                     emit;
   cmd_type                  emit_cmd;
   logic [PAGE_W-1:0]        emit_page;
   logic [PAGE_W-1:0]        emit_src;
   logic [BLK_W-1:0]         emit_blk;
   logic                     emit_status;
   logic                     emit_last;

   logic                     row_rd;
   logic                     row_we;
   logic [BLK_W-1:0]         row_waddr;
   logic [PAGES_PER_BLK-1:0] row_wdata;
   logic                     map_we;
   logic                     free_we;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign req_lbn    = req_sector_num[SECTOR_W-1:OFF_W];
   assign req_off    = req_sector_num[OFF_W-1:0];
   assign req_lbn_ok = (req_lbn < BLK_W'(DATA_BLOCKS));

   // The output register can take a command when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign row_cur  = row_qv_ff ? row_q_ff : '0;
   assign off_bit  = PAGES_PER_BLK'(1) << off_ff;
   // An overwrite programs into the spare block, other writes in place
   assign prog_blk = (kind_ff == WR_MOVE) ? free_ff : tgt_ff;

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      tgt_in      = tgt_ff;
      kind_in     = kind_ff;
      idx_in      = idx_ff;
      emit        = 1'b0;
      emit_cmd    = CMD_READ;
      emit_page   = '0;
      emit_src    = '0;
      emit_blk    = '0;
      emit_status = 1'b0;
      emit_last   = 1'b0;
      row_rd      = 1'b0;
      row_we      = 1'b0;
      row_waddr   = prog_blk;
      row_wdata   = row_cur | off_bit;
      map_we      = 1'b0;
      free_we     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_MAP;
            end
         end

         S_MAP: begin
            if (is_wr_ff == REQ_READ) begin
               // Answer a read here; an unmapped block reads page zero, flagged
               if (slot_free) begin
                  emit        = 1'b1;
                  emit_cmd    = CMD_READ;
                  emit_last   = 1'b1;
                  emit_status = !(lbn_ok_ff && hit_ff);
                  emit_page   = (lbn_ok_ff && hit_ff) ? {map_q_ff, off_ff} : '0;
                  state_in    = S_IDLE;
               end
            end else if (!lbn_ok_ff) begin
               // Drop a write beyond the last logical block
               state_in = S_IDLE;
            end else begin
               // A fresh block lands on logical block plus one
               tgt_in   = hit_ff ? map_q_ff : lbn_ff + BLK_W'(1);
               row_rd   = 1'b1;
               state_in = S_ROW;
            end
         end

         S_ROW: begin
            idx_in = '0;
            if (!hit_ff) begin
               kind_in  = WR_FRESH;
               // Page zero carries the marker itself
               state_in = (off_ff != '0) ? S_MARK : S_PROG;
            end else if (!row_cur[off_ff]) begin
               kind_in  = WR_FILL;
               state_in = S_PROG;
            end else begin
               kind_in  = WR_MOVE;
               state_in = S_COPY;
            end
         end

         S_MARK: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_cmd  = CMD_MARK;
               emit_page = {tgt_ff, OFF_W'(0)};
               state_in  = S_PROG;
            end
         end

         S_COPY: begin
            // Skip the page being rewritten, copy every other one in order
            if (idx_ff == off_ff || slot_free) begin
               if (idx_ff != off_ff) begin
                  emit      = 1'b1;
                  emit_cmd  = CMD_COPY;
                  emit_page = {free_ff, idx_ff};
                  emit_src  = {tgt_ff, idx_ff};
               end
               if (idx_ff == OFF_W'(PAGES_PER_BLK - 1)) begin
                  state_in = S_PROG;
               end else begin
                  idx_in = idx_ff + OFF_W'(1);
               end
            end
         end

         S_PROG: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_cmd  = CMD_PROG;
               emit_page = {prog_blk, off_ff};
               emit_last = (kind_ff != WR_MOVE);
               // Copied used bits plus the new page go to the target row
               row_we    = 1'b1;
               map_we    = (kind_ff != WR_FILL);
               state_in  = (kind_ff == WR_MOVE) ? S_ERASE : S_IDLE;
            end
         end

         S_ERASE: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_cmd  = CMD_ERASE;
               emit_blk  = tgt_ff;
               emit_last = 1'b1;
               // Clear the old row and make the old block the spare
               row_we    = 1'b1;
               row_waddr = tgt_ff;
               row_wdata = '0;
               free_we   = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         map_vld_ff   <= '0;
         row_vld_ff   <= '0;
         free_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (map_we) begin
            map_vld_ff[lbn_ff] <= 1'b1;
         end
         if (row_we) begin
            row_vld_ff[row_waddr] <= 1'b1;
         end
         if (free_we) begin
            free_ff <= tgt_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request context and output payload
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         is_wr_ff  <= req_type;
         lbn_ff    <= req_lbn;
         off_ff    <= req_off;
         lbn_ok_ff <= req_lbn_ok;
         hit_ff    <= req_lbn_ok && map_vld_ff[req_lbn];
      end
      tgt_ff  <= tgt_in;
      kind_ff <= kind_in;
      idx_ff  <= idx_in;
      if (emit) begin
         rsp_cmd_ff    <= emit_cmd;
         rsp_page_ff   <= emit_page;
         rsp_src_ff    <= emit_src;
         rsp_blk_ff    <= emit_blk;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   // ------------------------------------------------------------------------
   // Memories: one registered read and one write per cycle each. Reads and
   // writes of one request never overlap, so no forwarding is needed.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire && req_lbn_ok) begin
         map_q_ff <= map_mem[req_lbn];
      end
      if (map_we) begin
         map_mem[lbn_ff] <= prog_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (row_rd) begin
         row_q_ff  <= row_mem[tgt_in];
         row_qv_ff <= row_vld_ff[tgt_in];
      end
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
   end

   // ------------------------------------------------------------------------
   // Outputs
   // ------------------------------------------------------------------------
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cmd           = rsp_cmd_ff;
   assign rsp_page_addr     = rsp_page_ff;
   assign rsp_src_page_addr = rsp_src_ff;
   assign rsp_block_addr    = rsp_blk_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

>>> tb/sv/block_map_flash_translation_test.sv
`timescale 1ns / 1ps
// ============================================================================
// block_map_flash_translation_test
// Self-checking bench for the block-mapped flash translation block: sector
// requests are driven with random bursts and gaps, every flash command is
// compared field by field against a cycle-free model of the block map, the
// spare block and the page-use bitmap, with random and long output stalls.
// ============================================================================
module block_map_flash_translation_test
   import bmft_pkg::*;
();

   localparam int TOTAL_PAGES = NUM_BLOCKS * PAGES_PER_BLK;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES = 300;

   // one expected flash command
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [PAGE_W-1:0] page;
      logic [PAGE_W-1:0] src;
      logic [BLK_W-1:0]  blk;
      logic              status;
      logic              last;
   } flash_cmd_type;

   // receiver behavior
   localparam int RX_ALWAYS = 0;
   localparam int RX_CHOPPY = 1;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic [SECTOR_W-1:0] req_sector_num;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CMD_W-1:0]    rsp_cmd;
   logic [PAGE_W-1:0]   rsp_page_addr;
   logic [PAGE_W-1:0]   rsp_src_page_addr;
   logic [BLK_W-1:0]    rsp_block_addr;
   logic                rsp_status;
   logic                rsp_last;

   // model state: logical-to-physical map, spare block, page-use bitmap
   logic                map_ok   [DATA_BLOCKS];
   logic [BLK_W-1:0]    map_blk  [DATA_BLOCKS];
   logic [BLK_W-1:0]    spare_blk;
   logic                page_busy [TOTAL_PAGES];

   flash_cmd_type pending_cmds[$];

   int error_count;
   int requests_sent;
   int cmds_checked;
   int moves_seen;
   int fresh_seen;
   int unmapped_reads;
   int cycle_count;

   // sender burst control
   int burst_left;

   // receiver control: the main thread only bumps hold_asks, the receiver
   // owns the countdown
   int rx_mode;
   int hold_asks;

   block_map_flash_translation uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_sector_num    (req_sector_num),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cmd           (rsp_cmd),
      .rsp_page_addr     (rsp_page_addr),
      .rsp_src_page_addr (rsp_src_page_addr),
      .rsp_block_addr    (rsp_block_addr),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop: count cycles and give up far beyond the slowest legal run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d commands still expected",
               cycle_count, pending_cmds.size());
      $display("block_map_flash_translation verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Model of the translation layer
   // ------------------------------------------------------------------------

   function automatic logic [PAGE_W-1:0] page_at(logic [BLK_W-1:0] b, int off);
      logic [OFF_W-1:0] o;
      o = off[OFF_W-1:0];
      return {b, o};
   endfunction

   task automatic push_cmd(cmd_type c, logic [PAGE_W-1:0] page,
                           logic [PAGE_W-1:0] src, logic [BLK_W-1:0] blk,
                           logic status, logic last);
      flash_cmd_type e;
      e.cmd    = c;
      e.page   = page;
      e.src    = src;
      e.blk    = blk;
      e.status = status;
      e.last   = last;
      pending_cmds.push_back(e);
   endtask

   // Work out the flash commands of one accepted request and advance the model.
   task automatic predict_flash_cmds(logic rtype, logic [SECTOR_W-1:0] sector);
      int lbn;
      int off;
      int i;
      logic [BLK_W-1:0] old_blk;
      logic [BLK_W-1:0] new_blk;
      lbn = sector / PAGES_PER_BLK;
      off = sector % PAGES_PER_BLK;
      if (rtype == REQ_READ) begin
         // reads past the last logical block look like unmapped reads
         if (lbn >= DATA_BLOCKS || !map_ok[lbn]) begin
            push_cmd(CMD_READ, '0, '0, '0, 1'b1, 1'b1);
            unmapped_reads++;
         end else begin
            push_cmd(CMD_READ, page_at(map_blk[lbn], off), '0, '0, 1'b0, 1'b1);
         end
      end else if (lbn < DATA_BLOCKS) begin
         if (!map_ok[lbn]) begin
            // first write: map to lbn+1, marker on page 0 unless page 0 is the target
            new_blk = BLK_W'(lbn + 1);
            if (off != 0)
               push_cmd(CMD_MARK, page_at(new_blk, 0), '0, '0, 1'b0, 1'b0);
            push_cmd(CMD_PROG, page_at(new_blk, off), '0, '0, 1'b0, 1'b1);
            page_busy[page_at(new_blk, off)] = 1'b1;
            map_ok[lbn]  = 1'b1;
            map_blk[lbn] = new_blk;
            fresh_seen++;
         end else if (!page_busy[page_at(map_blk[lbn], off)]) begin
            push_cmd(CMD_PROG, page_at(map_blk[lbn], off), '0, '0, 1'b0, 1'b1);
            page_busy[page_at(map_blk[lbn], off)] = 1'b1;
         end else begin
            // overwrite: copy the other pages into the spare, program, erase old
            old_blk = map_blk[lbn];
            new_blk = spare_blk;
            for (i = 0; i < PAGES_PER_BLK; i++) begin
               if (i != off) begin
                  push_cmd(CMD_COPY, page_at(new_blk, i), page_at(old_blk, i), '0,
                           1'b0, 1'b0);
                  page_busy[page_at(new_blk, i)] = page_busy[page_at(old_blk, i)];
               end
            end
            push_cmd(CMD_PROG, page_at(new_blk, off), '0, '0, 1'b0, 1'b0);
            page_busy[page_at(new_blk, off)] = 1'b1;
            push_cmd(CMD_ERASE, '0, '0, old_blk, 1'b0, 1'b1);
            for (i = 0; i < PAGES_PER_BLK; i++)
               page_busy[page_at(old_blk, i)] = 1'b0;
            spare_blk    = old_blk;
            map_blk[lbn] = new_blk;
            moves_seen++;
         end
      end
      // writes past the last logical block produce nothing
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic flag_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         flag_mismatch($sformatf("command %0d field %s got %0d want %0d",
                                 cmds_checked, name, got, want));
   endtask

   // Sample every accepted command at the rising edge and compare it with the
   // oldest outstanding expectation.
   always @(posedge clock) begin
      flash_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            flag_mismatch($sformatf("unexpected command %0d page %0d", rsp_cmd,
                                    rsp_page_addr));
         end else begin
            want = pending_cmds.pop_front();
            check_field("cmd", rsp_cmd, want.cmd);
            check_field("page_addr", rsp_page_addr, want.page);
            check_field("src_page_addr", rsp_src_page_addr, want.src);
            check_field("block_addr", rsp_block_addr, want.blk);
            check_field("status", rsp_status, want.status);
            check_field("last", rsp_last, want.last);
         end
         cmds_checked++;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: always ready, or choppy runs of ready and stall; a hold request
   // drops ready until the hold countdown kept here runs out.
   // ------------------------------------------------------------------------
   initial begin
      int run_left;
      int hold_left;
      int holds_seen;
      logic run_high;
      run_left   = 0;
      hold_left  = 0;
      holds_seen = 0;
      run_high   = 1'b1;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_seen) begin
            holds_seen = hold_asks;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else if (rx_mode == RX_ALWAYS) begin
            rsp_ready = 1'b1;
         end else begin
            if (run_left == 0) begin
               run_high = ~run_high;
               run_left = run_high ? $urandom_range(1, 10) : $urandom_range(1, 5);
               // now and then a long stretch with no stall at all
               if (run_high && $urandom_range(0, 7) == 0)
                  run_left = 40;
            end
            run_left--;
            rsp_ready = run_high;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------

   // Offer one request and hold it until the block takes it; gaps fall
   // between bursts of random length.
   task automatic issue_request(logic rtype, logic [SECTOR_W-1:0] sector);
      @(negedge clock);
      if (burst_left <= 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
      end
      req_valid      = 1'b1;
      req_type       = rtype;
      req_sector_num = sector;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      requests_sent++;
      predict_flash_cmds(rtype, sector);
   endtask

   // Random well-formed traffic: mostly a few hot logical blocks so that
   // overwrites are frequent, some spread over all blocks, a little noise
   // past the last logical block.
   task automatic issue_random_request();
      int lbn;
      logic rtype;
      logic [SECTOR_W-1:0] sector;
      rtype = ($urandom_range(0, 9) < 6) ? REQ_WRITE : REQ_READ;
      if ($urandom_range(0, 11) == 0) begin
         sector = SECTOR_W'($urandom_range(DATA_BLOCKS * PAGES_PER_BLK,
                                           (1 << SECTOR_W) - 1));
      end else begin
         lbn = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                           : $urandom_range(0, DATA_BLOCKS - 1);
         sector = SECTOR_W'(lbn * PAGES_PER_BLK + $urandom_range(0, PAGES_PER_BLK - 1));
      end
      issue_request(rtype, sector);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reads right after reset: every block unmapped, including sectors past
   // the last logical block.
   task automatic test_reset_reads();
      issue_request(REQ_READ, 6'd0);
      issue_request(REQ_READ, 6'd59);
      issue_request(REQ_READ, 6'd60);
      issue_request(REQ_READ, 6'd63);
   endtask

   // First writes with and without the block marker, ignored writes past the
   // end, and reads through the fresh mappings.
   task automatic test_first_writes();
      issue_request(REQ_WRITE, 6'd1);
      issue_request(REQ_WRITE, 6'd4);
      issue_request(REQ_WRITE, 6'd60);
      issue_request(REQ_WRITE, 6'd63);
      issue_request(REQ_WRITE, 6'd59);
      issue_request(REQ_READ, 6'd1);
      issue_request(REQ_READ, 6'd4);
      issue_request(REQ_READ, 6'd59);
      issue_request(REQ_READ, 6'd62);
   endtask

   // Fill the free pages of a mapped block in place.
   task automatic test_fill_pages();
      issue_request(REQ_WRITE, 6'd2);
      issue_request(REQ_WRITE, 6'd3);
      issue_request(REQ_WRITE, 6'd0);
   endtask

   // Overwrites of a full block and of a partly used one, back to back, so
   // the spare block rotates; read the moved data back.
   task automatic test_overwrites();
      issue_request(REQ_WRITE, 6'd1);
      issue_request(REQ_WRITE, 6'd1);
      issue_request(REQ_WRITE, 6'd4);
      issue_request(REQ_WRITE, 6'd59);
      issue_request(REQ_READ, 6'd0);
      issue_request(REQ_READ, 6'd3);
      issue_request(REQ_READ, 6'd4);
      issue_request(REQ_READ, 6'd58);
   endtask

   task automatic test_random_traffic(int count);
      rx_mode = RX_CHOPPY;
      repeat (count) issue_random_request();
   endtask

   // Hold the receiver off for a long stretch while requests keep coming, so
   // the output register fills and the input stalls.
   task automatic test_backpressure(int count);
      hold_asks++;
      repeat (count) issue_request(REQ_WRITE,
                                   SECTOR_W'($urandom_range(0, 2 * PAGES_PER_BLK - 1)));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int i;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_READ;
      req_sector_num = '0;
      rx_mode        = RX_ALWAYS;
      hold_asks      = 0;
      burst_left     = 0;
      error_count    = 0;
      requests_sent  = 0;
      cmds_checked   = 0;
      moves_seen     = 0;
      fresh_seen     = 0;
      unmapped_reads = 0;
      // model reset: all unmapped, all pages free, block 0 is the spare
      for (i = 0; i < DATA_BLOCKS; i++) begin
         map_ok[i]  = 1'b0;
         map_blk[i] = '0;
      end
      for (i = 0; i < TOTAL_PAGES; i++)
         page_busy[i] = 1'b0;
      spare_blk = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_reads();
      test_first_writes();
      test_fill_pages();
      test_overwrites();
      test_random_traffic(300);
      test_backpressure(30);
      test_random_traffic(20);

      // drop valid and drain
      @(negedge clock);
      req_valid = 1'b0;
      rx_mode   = RX_ALWAYS;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d commands: %0d first writes, %0d overwrites,",
               requests_sent, cmds_checked, fresh_seen, moves_seen);
      $display("%0d unmapped reads; bursty input, choppy output and one long output hold",
               unmapped_reads);
      if (error_count == 0) begin
         $display("block_map_flash_translation verification clean");
      end else begin
         $display("block_map_flash_translation verification failed");
      end
      $finish;
   end

endmodule
